// ===== rtl/core/lsfbe_pkg.sv =====
package lsfbe_pkg;

    // Strip geometry: one memory row holds the three color bytes of one LED.
    localparam int MAX_LEDS   = 256;
    localparam int ROW_W      = $clog2(MAX_LEDS);
    localparam int LED_CNT_W  = ROW_W + 1;
    localparam int LEN_W      = 9;
    localparam int TICK_W     = 15;
    localparam int COLOR_W    = 8;
    localparam int ROW_DATA_W = 3 * COLOR_W;
    localparam int PROD_W     = 2 * COLOR_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_HALF      = 3'd5;

    // Operation codes of an input item.
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Result kinds.
    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_ZERO   = 2'd1;
    localparam logic [1:0] RK_ONE    = 2'd2;
    localparam logic [1:0] RK_RESET  = 2'd3;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_INDEX = 1'b1;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]         operation;
        logic [COLOR_W-1:0] pixel_index;
        logic [COLOR_W-1:0] red_value;
        logic [COLOR_W-1:0] green_value;
        logic [COLOR_W-1:0] blue_value;
        logic [COLOR_W-1:0] brightness;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [TICK_W-1:0] first_ticks;
        logic [TICK_W-1:0] second_ticks;
        logic              status;
        logic              last;
        logic              frame_done;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]  strip_length;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] zero_low_ticks;
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] one_low_ticks;
        logic [TICK_W-1:0] reset_half_ticks;
    } t_cfg;

    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_WERR   = 3'd1,
        K_FILL   = 3'd2,
        K_ENCODE = 3'd3,
        K_NOP    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ROW_W-1:0]   index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] brightness;
    } t_cmd;

    // Number of LEDs actually in use: the register saturates at the strip maximum.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] sl);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(MAX_LEDS);
        return (sl > lim) ? lim : sl;
    endfunction

    // Floor of x/255 for any 16-bit product of two bytes, without a divider.
    function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {9'd0, x[PROD_W-1:COLOR_W]} + {{PROD_W{1'b0}}, 1'b1};
        return t[PROD_W-1:COLOR_W];
    endfunction

endpackage

// ===== rtl/core/lsfbe_front.sv =====
module lsfbe_front
    import lsfbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_in_valid,
    input  t_in_item         i_in_item,
    output logic             o_in_stall,
    input  logic             i_q_pop,
    output logic             o_q_valid,
    output t_cmd             o_q_cmd
);

    t_cmd              w_cmd;
    logic              w_push;
    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    // Classify the item; the index check happens here so the back end only executes.
    always_comb begin
        w_cmd.index      = i_in_item.pixel_index;
        w_cmd.red        = i_in_item.red_value;
        w_cmd.green      = i_in_item.green_value;
        w_cmd.blue       = i_in_item.blue_value;
        w_cmd.brightness = i_in_item.brightness;
        case (i_in_item.operation)
            OP_WRITE: begin
                if ({1'b0, i_in_item.pixel_index} >= i_len) begin
                    w_cmd.kind = K_WERR;
                end else begin
                    w_cmd.kind = K_WRITE;
                end
            end
            OP_FILL:   w_cmd.kind = K_FILL;
            OP_ENCODE: w_cmd.kind = K_ENCODE;
            default:   w_cmd.kind = K_NOP;
        endcase
    end

    assign o_in_stall = (r_count == QCNT_W'(QDEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_cmd    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("command queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != '0)
        else $error("command popped from an empty queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/core/lsfbe_back.sv =====
module lsfbe_back
    import lsfbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_WWR  = 8'b0000_0100,
        S_FILL = 8'b0000_1000,
        S_ST   = 8'b0001_0000,
        S_RST  = 8'b0010_0000,
        S_ERD  = 8'b0100_0000,
        S_EBIT = 8'b1000_0000
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic                   r_status, n_status;
    logic [PROD_W-1:0]      r_prod_r, r_prod_g, r_prod_b;
    logic [LED_CNT_W-1:0]   r_row, n_row;
    logic [LED_CNT_W-1:0]   r_led, n_led;
    logic [1:0]             r_sub, n_sub;
    logic [2:0]             r_bit, n_bit;
    logic [COLOR_W-1:0]     r_shift, n_shift;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic [ROW_DATA_W-1:0]  r_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0]    r_row_vld;
    logic [ROW_DATA_W-1:0]  r_rd_data;
    logic                   r_rd_vld;

    logic                   w_mem_we;
    logic [ROW_W-1:0]       w_mem_addr;
    logic [ROW_DATA_W-1:0]  w_mem_wdata;
    logic [LEN_W-1:0]       w_len;
    logic                   w_can_emit;
    logic                   w_emit;
    t_out_item              w_emit_item;
    logic [ROW_DATA_W-1:0]  w_row_data;
    logic [COLOR_W-1:0]     w_sel_byte;

    assign w_len      = eff_len(i_cfg.strip_length);
    assign w_can_emit = !r_out_valid || !i_out_stall;
    assign w_row_data = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        case (r_sub)
            2'd0:    w_sel_byte = w_row_data[3*COLOR_W-1:2*COLOR_W];
            2'd1:    w_sel_byte = w_row_data[2*COLOR_W-1:COLOR_W];
            default: w_sel_byte = w_row_data[COLOR_W-1:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_row       = r_row;
        n_led       = r_led;
        n_sub       = r_sub;
        n_bit       = r_bit;
        n_shift     = r_shift;
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_cmd.index;
        w_mem_wdata = {div255(r_prod_r), div255(r_prod_g), div255(r_prod_b)};
        w_emit      = 1'b0;
        w_emit_item = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_row   = '0;
                    case (i_q_cmd.kind)
                        K_WRITE: n_state = S_MUL;
                        K_WERR: begin
                            n_status = ST_BAD_INDEX;
                            n_state  = S_ST;
                        end
                        K_FILL: n_state = S_FILL;
                        K_ENCODE: begin
                            if ({1'b0, r_led} >= {1'b0, w_len}) begin
                                n_state = S_RST;
                            end else begin
                                n_state = S_ERD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                            n_state  = S_ST;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_WWR;
            end
            S_WWR: begin
                w_mem_we = 1'b1;
                n_status = ST_OK;
                n_state  = S_ST;
            end
            S_FILL: begin
                if (r_row < w_len) begin
                    w_mem_we    = 1'b1;
                    w_mem_addr  = r_row[ROW_W-1:0];
                    w_mem_wdata = {r_cmd.red, r_cmd.green, r_cmd.blue};
                    n_row       = r_row + 1'b1;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_ST;
                end
            end
            S_ST: begin
                if (w_can_emit) begin
                    w_emit             = 1'b1;
                    w_emit_item.status = r_status;
                    w_emit_item.last   = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_RST: begin
                if (w_can_emit) begin
                    w_emit                   = 1'b1;
                    w_emit_item.result_kind  = RK_RESET;
                    w_emit_item.first_ticks  = i_cfg.reset_half_ticks;
                    w_emit_item.second_ticks = i_cfg.reset_half_ticks;
                    w_emit_item.last         = 1'b1;
                    w_emit_item.frame_done   = 1'b1;
                    n_led                    = '0;
                    n_sub                    = '0;
                    n_state                  = S_IDLE;
                end
            end
            S_ERD: begin
                n_shift = w_sel_byte;
                n_bit   = '0;
                n_state = S_EBIT;
            end
            S_EBIT: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    if (r_shift[COLOR_W-1]) begin
                        w_emit_item.result_kind  = RK_ONE;
                        w_emit_item.first_ticks  = i_cfg.one_high_ticks;
                        w_emit_item.second_ticks = i_cfg.one_low_ticks;
                    end else begin
                        w_emit_item.result_kind  = RK_ZERO;
                        w_emit_item.first_ticks  = i_cfg.zero_high_ticks;
                        w_emit_item.second_ticks = i_cfg.zero_low_ticks;
                    end
                    w_emit_item.last = (r_bit == 3'd7);
                    n_shift = {r_shift[COLOR_W-2:0], 1'b0};
                    n_bit   = r_bit + 1'b1;
                    if (r_bit == 3'd7) begin
                        n_state = S_IDLE;
                        if (r_sub == 2'd2) begin
                            n_sub = '0;
                            n_led = r_led + 1'b1;
                        end else begin
                            n_sub = r_sub + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_emit_item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_led       <= '0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
            r_row_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_led       <= n_led;
            r_sub       <= n_sub;
            r_out_valid <= n_out_valid;
            if (w_mem_we) begin
                r_row_vld[w_mem_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_row    <= n_row;
        r_bit    <= n_bit;
        r_shift  <= n_shift;
        r_out    <= n_out;
        if (r_state == S_MUL) begin
            r_prod_r <= PROD_W'(r_cmd.red * r_cmd.brightness);
            r_prod_g <= PROD_W'(r_cmd.green * r_cmd.brightness);
            r_prod_b <= PROD_W'(r_cmd.blue * r_cmd.brightness);
        end
    end

    // Pixel memory: one write port, one registered read port at the LED pointer.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[r_led[ROW_W-1:0]];
        r_rd_vld  <= r_row_vld[r_led[ROW_W-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && i_q_valid)
        else $error("command taken outside idle");

    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_item.frame_done) |=> (r_led == '0) && (r_sub == '0))
        else $error("byte pointer not rewound after frame end");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd3) && (r_led <= LED_CNT_W'(MAX_LEDS)))
        else $error("byte pointer out of range");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a waiting result");
`endif

endmodule

// ===== rtl/core/led_strip_frame_buffer_encoder_top.sv =====
// Order: a pixel write passes the multiply and memory-write states before its
// status item, and a fill writes every row of the strip before its status item.
// Throughput: one back-end sequencer executes items in order; an encode is a
// memory read plus eight symbols, one a cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous) empties the queue, rewinds the byte pointer,
// clears every pixel through per-LED valid bits and reloads the default timings.
module led_strip_frame_buffer_encoder_top
    import lsfbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall
);

    // The configuration bank. The user must write it only while the block is idle;
    // it is not enforced here. The front and back end read these registers directly.
    t_cfg r_cfg;
    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strip_length     <= LEN_W'(1);
            r_cfg.zero_high_ticks  <= TICK_W'(3);
            r_cfg.zero_low_ticks   <= TICK_W'(9);
            r_cfg.one_high_ticks   <= TICK_W'(9);
            r_cfg.one_low_ticks    <= TICK_W'(3);
            r_cfg.reset_half_ticks <= TICK_W'(250);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STRIP_LENGTH:    r_cfg.strip_length     <= i_cfg_wdata[LEN_W-1:0];
                CFG_ZERO_HIGH_TICKS: r_cfg.zero_high_ticks  <= i_cfg_wdata[TICK_W-1:0];
                CFG_ZERO_LOW_TICKS:  r_cfg.zero_low_ticks   <= i_cfg_wdata[TICK_W-1:0];
                CFG_ONE_HIGH_TICKS:  r_cfg.one_high_ticks   <= i_cfg_wdata[TICK_W-1:0];
                CFG_ONE_LOW_TICKS:   r_cfg.one_low_ticks    <= i_cfg_wdata[TICK_W-1:0];
                CFG_RESET_HALF:      r_cfg.reset_half_ticks <= i_cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each item, including the pixel index check, and
    // parks it in a two-entry queue so input acceptance keeps going, until the
    // queue is full, while the back end is busy serializing.
    lsfbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_len      (eff_len(r_cfg.strip_length)),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_pop    (w_q_pop),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd)
    );

    // The back end owns the pixel memory and the byte pointer, and emits result
    // items through a single output register.
    lsfbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== dv/led_strip_frame_buffer_encoder_top_test.sv =====
`timescale 1ns / 100ps

module led_strip_frame_buffer_encoder_top_test;
    import lsfbe_pkg::*;

    // The run is cut off here if the block hangs. The slowest correct run,
    // with every item paying its longest gap, every symbol its longest stall
    // and every fill the widest strip, stays well below this.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 345;
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_item = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  i_out_stall = 1'b0;

    led_strip_frame_buffer_encoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the block: register settings, the pixel store and the
    // pointer to the next byte to serialize.
    t_cfg        strip_cfg;
    logic [7:0]  shadow_pixels [0:3*MAX_LEDS-1];
    int unsigned byte_ptr;

    // Results that the shadow copy has produced and the block still owes,
    // oldest first.
    t_out_item   awaited_q[$];

    int          mismatch_count = 0;
    longint      cycle_count = 0;
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;
    bit          result_taken = 1'b0;
    int          stall_left = 0;

    // Number of LEDs in use: the length register saturates at the store size.
    function automatic int unsigned active_leds();
        return (strip_cfg.strip_length > MAX_LEDS) ? MAX_LEDS : strip_cfg.strip_length;
    endfunction

    // Brightness scaling, rounded down.
    function automatic logic [7:0] scale_colour(input logic [7:0] c, input logic [7:0] b);
        int unsigned prod;
        prod = c * b;
        return 8'(prod / 255);
    endfunction

    // Runs one accepted item through the shadow copy and queues every result
    // that it must cause.
    task automatic strip_predict(input t_in_item it);
        int unsigned len;
        int unsigned base;
        logic [7:0]  sym_byte;
        t_out_item   r;
        len = active_leds();
        r = '0;
        r.result_kind = RK_STATUS;
        r.status = ST_OK;
        r.last = 1'b1;
        case (it.operation)
            OP_WRITE: begin
                if (it.pixel_index >= len) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    base = it.pixel_index * 3;
                    shadow_pixels[base]     = scale_colour(it.red_value, it.brightness);
                    shadow_pixels[base + 1] = scale_colour(it.green_value, it.brightness);
                    shadow_pixels[base + 2] = scale_colour(it.blue_value, it.brightness);
                end
                awaited_q.push_back(r);
            end
            OP_FILL: begin
                for (int i = 0; i < len; i++) begin
                    shadow_pixels[3*i]     = it.red_value;
                    shadow_pixels[3*i + 1] = it.green_value;
                    shadow_pixels[3*i + 2] = it.blue_value;
                end
                awaited_q.push_back(r);
            end
            OP_ENCODE: begin
                if (byte_ptr < 3 * len) begin
                    // One symbol per bit, most significant bit first.
                    sym_byte = shadow_pixels[byte_ptr];
                    for (int k = 7; k >= 0; k--) begin
                        r = '0;
                        r.status = ST_OK;
                        if (sym_byte[k]) begin
                            r.result_kind  = RK_ONE;
                            r.first_ticks  = strip_cfg.one_high_ticks;
                            r.second_ticks = strip_cfg.one_low_ticks;
                        end else begin
                            r.result_kind  = RK_ZERO;
                            r.first_ticks  = strip_cfg.zero_high_ticks;
                            r.second_ticks = strip_cfg.zero_low_ticks;
                        end
                        r.last = (k == 0);
                        awaited_q.push_back(r);
                    end
                    byte_ptr++;
                end else begin
                    // Whole frame sent, or the strip shrank below the pointer.
                    r.result_kind  = RK_RESET;
                    r.first_ticks  = strip_cfg.reset_half_ticks;
                    r.second_ticks = strip_cfg.reset_half_ticks;
                    r.frame_done   = 1'b1;
                    byte_ptr = 0;
                    awaited_q.push_back(r);
                end
            end
            default: begin
                awaited_q.push_back(r);
            end
        endcase
    endtask

    // Register write; the shadow settings follow as the write is driven.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_STRIP_LENGTH:    strip_cfg.strip_length     = data[LEN_W-1:0];
            CFG_ZERO_HIGH_TICKS: strip_cfg.zero_high_ticks  = data;
            CFG_ZERO_LOW_TICKS:  strip_cfg.zero_low_ticks   = data;
            CFG_ONE_HIGH_TICKS:  strip_cfg.one_high_ticks   = data;
            CFG_ONE_LOW_TICKS:   strip_cfg.one_low_ticks    = data;
            CFG_RESET_HALF:      strip_cfg.reset_half_ticks = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one item. With hold set, the sender first waits until the block
    // owes nothing more. Returns at the edge that accepted the item, with
    // valid still high so that a back-to-back item needs no extra edge.
    task automatic send_item(input t_in_item it, input bit hold);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0 || hold) begin
            i_in_valid <= 1'b0;
            if (hold) begin
                do @(negedge i_clk); while (awaited_q.size() != 0);
            end else begin
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        strip_predict(it);
    endtask

    // Lets the block go idle so that registers may be written.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] op, input logic [7:0] idx,
                                           input logic [7:0] red, input logic [7:0] green,
                                           input logic [7:0] blue, input logic [7:0] bright);
        t_in_item it;
        it.operation   = op;
        it.pixel_index = idx;
        it.red_value   = red;
        it.green_value = green;
        it.blue_value  = blue;
        it.brightness  = bright;
        return it;
    endfunction

    // Tick values lean on the extremes now and then.
    function automatic logic [CFG_DATA_W-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 15'd1;
            2: return 15'h7FFF;
            3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Mostly short strips so that frames run to their end; now and then an
    // empty strip, a wide one or one above the store size.
    function automatic logic [CFG_DATA_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(7, 256));
            2: return CFG_DATA_W'($urandom_range(257, 511));
            default: return CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Out of reset: length 1, default timings and a cleared store.
    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_item(make_item(OP_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
        send_item(make_item(OP_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        // Full brightness stores the colour unchanged.
        send_item(make_item(OP_WRITE, 8'd0, 8'h12, 8'h34, 8'hC9, 8'd255), 1'b0);
        send_item(make_item(OP_WRITE, 8'd1, 8'h12, 8'h34, 8'h56, 8'd255), 1'b0);
        repeat (3) send_item(make_item(OP_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        wait_idle();
    endtask

    // Fill, scaled writes and one whole frame over a two-LED strip. The
    // rejected write waits until the block owes nothing.
    task automatic test_fill_and_scale();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        cfg_write(CFG_STRIP_LENGTH, 15'd2);
        send_item(make_item(OP_FILL, 8'd0, 8'h55, 8'hAA, 8'hFF, 8'd0), 1'b0);
        send_item(make_item(OP_WRITE, 8'd1, 8'hFF, 8'hC8, 8'h01, 8'd254), 1'b0);
        send_item(make_item(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd0), 1'b0);
        send_item(make_item(OP_WRITE, 8'd255, 8'h01, 8'h02, 8'h03, 8'd128), 1'b1);
        repeat (7) send_item(make_item(OP_ENCODE, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF), 1'b0);
        wait_idle();
    endtask

    // An empty strip rejects every write, fills nothing and ends the frame at
    // once.
    task automatic test_empty_strip();
        cfg_write(CFG_STRIP_LENGTH, 15'd0);
        send_item(make_item(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd255), 1'b0);
        send_item(make_item(OP_FILL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd255), 1'b0);
        send_item(make_item(OP_ENCODE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        wait_idle();
        cfg_write(CFG_STRIP_LENGTH, 15'd1);
        send_item(make_item(OP_ENCODE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        wait_idle();
    endtask

    // A length above the store size saturates; the timing registers go to
    // their extremes, zero included; shrinking the strip mid-frame rewinds.
    task automatic test_wide_strip();
        cfg_write(CFG_ZERO_HIGH_TICKS, 15'd0);
        cfg_write(CFG_ZERO_LOW_TICKS, 15'h7FFF);
        cfg_write(CFG_ONE_HIGH_TICKS, 15'h7FFF);
        cfg_write(CFG_ONE_LOW_TICKS, 15'd0);
        cfg_write(CFG_RESET_HALF, 15'd0);
        cfg_write(CFG_STRIP_LENGTH, 15'd300);
        send_item(make_item(OP_FILL, 8'd7, 8'h81, 8'h7E, 8'h00, 8'd9), 1'b0);
        send_item(make_item(OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'd255), 1'b0);
        repeat (4) send_item(make_item(OP_ENCODE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        wait_idle();
        // The pointer now stands past the three bytes of a one-LED strip.
        cfg_write(CFG_STRIP_LENGTH, 15'd1);
        cfg_write(CFG_RESET_HALF, 15'h7FFF);
        send_item(make_item(OP_ENCODE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        send_item(make_item(OP_ENCODE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        wait_idle();
    endtask

    // Phases of random items, each under fresh register settings and its own
    // mix of idling. Encodes dominate so that frames run to their reset
    // symbol; writes, fills and the unused operation are mixed in.
    task automatic test_random_traffic();
        int          sent;
        int          phase_items;
        int          sel;
        int unsigned len;
        t_in_item    it;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            cfg_write(CFG_STRIP_LENGTH, pick_length());
            cfg_write(CFG_ZERO_HIGH_TICKS, pick_ticks());
            cfg_write(CFG_ZERO_LOW_TICKS, pick_ticks());
            cfg_write(CFG_ONE_HIGH_TICKS, pick_ticks());
            cfg_write(CFG_ONE_LOW_TICKS, pick_ticks());
            cfg_write(CFG_RESET_HALF, pick_ticks());
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            len = active_leds();
            phase_items = $urandom_range(20, 45);
            if (phase_items > RANDOM_ITEMS - sent) begin
                phase_items = RANDOM_ITEMS - sent;
            end
            repeat (phase_items) begin
                it.pixel_index = 8'($urandom);
                it.red_value   = 8'($urandom);
                it.green_value = 8'($urandom);
                it.blue_value  = 8'($urandom);
                it.brightness  = 8'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    it.operation = OP_WRITE;
                    if (len > 0 && $urandom_range(0, 4) != 0)
                        it.pixel_index = 8'($urandom_range(0, len - 1));
                    case ($urandom_range(0, 9))
                        0, 1, 2: it.brightness = 8'd255;
                        3:       it.brightness = 8'd0;
                        default: ;
                    endcase
                end else if (sel < 25) begin
                    it.operation = OP_FILL;
                end else if (sel < 95) begin
                    it.operation = OP_ENCODE;
                end else begin
                    it.operation = OP_NOP;
                end
                send_item(it, $urandom_range(0, 39) == 0);
                sent++;
            end
            wait_idle();
        end
    endtask

    // Receiver: stalls for a random number of cycles after each result.
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            stall_left = stalls_on ? $urandom_range(0, 16) : 0;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Each accepted result is held against the oldest one still owed.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_taken = 1'b1;
            if (awaited_q.size() == 0) begin
                $error("unexpected result item: kind %0d", o_out_item.result_kind);
                mismatch_count++;
            end else begin
                want = awaited_q.pop_front();
                if (o_out_item.result_kind !== want.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, o_out_item.result_kind);
                    mismatch_count++;
                end
                if (o_out_item.first_ticks !== want.first_ticks) begin
                    $error("first_ticks: expected %0d, got %0d",
                           want.first_ticks, o_out_item.first_ticks);
                    mismatch_count++;
                end
                if (o_out_item.second_ticks !== want.second_ticks) begin
                    $error("second_ticks: expected %0d, got %0d",
                           want.second_ticks, o_out_item.second_ticks);
                    mismatch_count++;
                end
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    mismatch_count++;
                end
                if (o_out_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_item.last);
                    mismatch_count++;
                end
                if (o_out_item.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d",
                           want.frame_done, o_out_item.frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // Shadow state after reset: defaults and an all-zero store.
        strip_cfg = '{9'd1, 15'd3, 15'd9, 15'd9, 15'd3, 15'd250};
        foreach (shadow_pixels[i]) shadow_pixels[i] = 8'h00;
        byte_ptr = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_fill_and_scale();
        test_empty_strip();
        test_wide_strip();
        test_random_traffic();

        // Everything has been sent; let the last results drain out.
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (awaited_q.size() != 0) begin
            $error("%0d result items never arrived", awaited_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
